// ===== design/egsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsa_pkg
// shared types and constants of the embedding gather / scatter-add engine
// ----------------------------------------------------------------------------
package egsa_pkg;

	// input action codes
	typedef enum logic [2:0] {
		ACT_LOAD   = 3'd0,
		ACT_LOOKUP = 3'd1,
		ACT_CLEAR  = 3'd2,
		ACT_ACC    = 3'd3,
		ACT_READ   = 3'd4
	} action_t;

	// register index, taken from paddr[2]
	localparam logic REG_VOCAB_ROWS = 1'b0;
	localparam logic REG_ROW_WIDTH  = 1'b1;

	localparam logic [10:0] VOCAB_ROWS_RST = 11'd1024;
	localparam logic [6:0]  ROW_WIDTH_RST  = 7'd64;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC_WR,
		ST_ERR,
		ST_MISS,
		ST_GRD_OUT,
		ST_LK_OUT
	} state_t;

	// source of the next result beat
	typedef enum logic [2:0] {
		OUT_NONE,
		OUT_ERR,
		OUT_MISS,
		OUT_GRD,
		OUT_LK
	} out_sel_t;

	typedef struct packed {
		logic     ready;      // input side may take a beat
		logic     capture;    // latch item fields
		logic     w_we;       // weight element write
		logic     g_re;       // gradient read at item address
		logic     acc_we;     // gradient write of saturated sum
		logic     clr_step;   // gradient clear, one entry
		logic     lk_start;   // first weight read of a lookup row
		logic     lk_next;    // next weight read of the row
		out_sel_t out_sel;
	} dp_cmd_t;

	typedef struct packed {
		action_t act;
		logic    tok_ok;
		logic    col_ok;
		logic    slot_free;   // output register can load this cycle
		logic    clr_last;
		logic    lk_last;
	} dp_sts_t;

endpackage

// ===== design/egsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module egsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/egsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsa_ctrl
// sequencer: decodes an item and steps the datapath through its actions
// ----------------------------------------------------------------------------
module egsa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  egsa_pkg::dp_sts_t  sts,
	output egsa_pkg::dp_cmd_t  cmd
);
	import egsa_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.out_sel = OUT_NONE;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (sts.act)
						ACT_LOAD: begin
							if (!sts.tok_ok) begin
								state_nxt = ST_ERR;
							end else if (sts.col_ok) begin
								cmd.w_we = 1'b1;
							end
						end
						ACT_LOOKUP: begin
							if (!sts.tok_ok) begin
								state_nxt = ST_ERR;
							end else begin
								cmd.lk_start = 1'b1;
								state_nxt    = ST_LK_OUT;
							end
						end
						ACT_CLEAR: begin
							state_nxt = ST_CLEAR;
						end
						ACT_ACC: begin
							if (!sts.tok_ok) begin
								state_nxt = ST_ERR;
							end else if (sts.col_ok) begin
								cmd.g_re  = 1'b1;
								state_nxt = ST_ACC_WR;
							end
						end
						ACT_READ: begin
							if (!sts.tok_ok) begin
								state_nxt = ST_ERR;
							end else if (sts.col_ok) begin
								cmd.g_re  = 1'b1;
								state_nxt = ST_GRD_OUT;
							end else begin
								state_nxt = ST_MISS;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_ACC_WR: begin
				cmd.acc_we = 1'b1;
				state_nxt  = ST_IDLE;
			end
			ST_ERR: begin
				if (sts.slot_free) begin
					cmd.out_sel = OUT_ERR;
					state_nxt   = ST_IDLE;
				end
			end
			ST_MISS: begin
				if (sts.slot_free) begin
					cmd.out_sel = OUT_MISS;
					state_nxt   = ST_IDLE;
				end
			end
			ST_GRD_OUT: begin
				if (sts.slot_free) begin
					cmd.out_sel = OUT_GRD;
					state_nxt   = ST_IDLE;
				end
			end
			ST_LK_OUT: begin
				if (sts.slot_free) begin
					cmd.out_sel = OUT_LK;
					if (sts.lk_last) begin
						state_nxt = ST_IDLE;
					end else begin
						cmd.lk_next = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/egsa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsa_dp
// datapath: weight and gradient rams, item registers, saturating adder,
// clear counter and result register
// ----------------------------------------------------------------------------
module egsa_dp #(
	parameter int VOCAB = 1024,
	parameter int DIM   = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [10:0]        vocab_rows,
	input  logic [6:0]         row_width,
	input  logic [2:0]         action,
	input  logic [9:0]         token_index,
	input  logic [5:0]         column,
	input  logic signed [31:0] value,
	input  egsa_pkg::dp_cmd_t  cmd,
	output egsa_pkg::dp_sts_t  sts,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] data,
	output logic [5:0]         position,
	output logic               last,
	output logic               error
);
	import egsa_pkg::*;

	localparam int RW    = $clog2(VOCAB);
	localparam int CW    = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int AW    = RW + CW;
	localparam int DEPTH = VOCAB * (2 ** CW);

	logic [16:0]   tok_ext;
	logic [RW-1:0] in_row;
	logic [AW-1:0] in_addr;
	logic [6:0]    w_use;
	logic          tok_ok;

	logic [RW-1:0] row_q;
	logic [5:0]    col_q;
	logic [31:0]   val_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] k_inc;
	logic [AW-1:0] clr_cnt_q;
	logic          clr_last;
	logic          lk_last;

	logic          w_re;
	logic [AW-1:0] w_raddr;
	logic [31:0]   w_rdata;
	logic          g_we;
	logic [AW-1:0] g_waddr;
	logic [31:0]   g_wdata;
	logic [31:0]   g_rdata;

	logic [32:0]   sum;
	logic [31:0]   sum_sat;

	logic          out_valid_q;
	logic [31:0]   data_q;
	logic [5:0]    pos_q;
	logic          last_q;
	logic          err_q;
	logic          slot_free;

	// item decode
	assign tok_ext = 17'(token_index);
	assign in_row  = tok_ext[RW-1:0];
	assign in_addr = {in_row, column[CW-1:0]};
	assign tok_ok  = ({1'b0, token_index} < vocab_rows) && (32'(token_index) < 32'(VOCAB));

	always_comb begin
		if (row_width == 7'd0) begin
			w_use = 7'd1;
		end else if (row_width > 7'(DIM)) begin
			w_use = 7'(DIM);
		end else begin
			w_use = row_width;
		end
	end

	assign k_inc    = k_q + CW'(1);
	assign lk_last  = (7'(k_q) == (w_use - 7'd1));
	assign clr_last = (clr_cnt_q == AW'(DEPTH - 1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q <= in_row;
			col_q <= column;
			val_q <= value;
		end
		if (cmd.lk_start) begin
			k_q <= '0;
		end else if (cmd.lk_next) begin
			k_q <= k_inc;
		end
	end

	// clear sweep counter, back at zero after every pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_last ? '0 : clr_cnt_q + AW'(1);
		end
	end

	// weight table
	assign w_re    = cmd.lk_start | cmd.lk_next;
	assign w_raddr = cmd.lk_start ? {in_row, CW'(0)} : {row_q, k_inc};

	egsa_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (cmd.w_we),
		.waddr (in_addr),
		.wdata (value),
		.re    (w_re),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// saturating q16.16 accumulate
	assign sum = {g_rdata[31], g_rdata} + {val_q[31], val_q};
	always_comb begin
		if (sum[32] != sum[31]) begin
			sum_sat = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			sum_sat = sum[31:0];
		end
	end

	// gradient table
	assign g_we    = cmd.clr_step | cmd.acc_we;
	assign g_waddr = cmd.clr_step ? clr_cnt_q : {row_q, col_q[CW-1:0]};
	assign g_wdata = cmd.clr_step ? 32'd0 : sum_sat;

	egsa_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_grad_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.re    (cmd.g_re),
		.raddr (in_addr),
		.rdata (g_rdata)
	);

	// result register
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_sel != OUT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			OUT_ERR: begin
				data_q <= 32'd0;
				pos_q  <= 6'd0;
				last_q <= 1'b1;
				err_q  <= 1'b1;
			end
			OUT_MISS: begin
				data_q <= 32'd0;
				pos_q  <= col_q;
				last_q <= 1'b1;
				err_q  <= 1'b0;
			end
			OUT_GRD: begin
				data_q <= g_rdata;
				pos_q  <= col_q;
				last_q <= 1'b1;
				err_q  <= 1'b0;
			end
			OUT_LK: begin
				data_q <= w_rdata;
				pos_q  <= 6'(k_q);
				last_q <= lk_last;
				err_q  <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign position  = pos_q;
	assign last      = last_q;
	assign error     = err_q;

	assign sts.act       = action_t'(action);
	assign sts.tok_ok    = tok_ok;
	assign sts.col_ok    = ({1'b0, column} < w_use);
	assign sts.slot_free = slot_free;
	assign sts.clr_last  = clr_last;
	assign sts.lk_last   = lk_last;

endmodule

// ===== design/embedding_gather_scatter_add.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// embedding_gather_scatter_add
// embedding engine: q16.16 weight table with row lookup, and a gradient
// table with saturating scatter-add, clear and element read
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  in       | in_valid / in_stall        | action, token_index, column, value
//  out      | out_valid / out_stall      | data, position, last, error
//  config   | apb psel/penable/pready    | paddr, pwdata, prdata
//
// per item: load writes the weight element as the beat is taken, accumulate
// does a gradient ram read then the write, read does the gradient ram read
// then waits for the output, bad token or read past the row waits for the
// output only, lookup streams the row one element a cycle while out_stall
// is low, clear writes every gradient entry, one a cycle through the single
// ram write port
// after reset the same clearing pass runs before the first beat is taken;
// config writes are taken throughout
// one result register sits on the output, so the next item is taken while
// an earlier result still waits under out_stall
// ----------------------------------------------------------------------------
module embedding_gather_scatter_add #(
	parameter int VOCAB = 1024,
	parameter int DIM   = 64
) (
	input  logic               clk,
	input  logic               arst_n,

	// item channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [9:0]         token_index,
	input  logic [5:0]         column,
	input  logic signed [31:0] value,

	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] data,
	output logic [5:0]         position,
	output logic               last,
	output logic               error,

	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import egsa_pkg::*;

	logic [10:0] vocab_rows_q;
	logic [6:0]  row_width_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;

	// register file, byte address 4*i; paddr[2] picks the register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_rows_q <= VOCAB_ROWS_RST;
			row_width_q  <= ROW_WIDTH_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_VOCAB_ROWS: vocab_rows_q <= pwdata[10:0];
				REG_ROW_WIDTH:  row_width_q  <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_VOCAB_ROWS: prdata = 32'(vocab_rows_q);
			REG_ROW_WIDTH:  prdata = 32'(row_width_q);
			default:        prdata = 32'd0;
		endcase
	end

	// sequencer, takes a beat only in its idle state
	egsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign in_stall = !cmd.ready;

	// tables, adder and result register
	egsa_dp #(
		.VOCAB (VOCAB),
		.DIM   (DIM)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.vocab_rows  (vocab_rows_q),
		.row_width   (row_width_q),
		.action      (action),
		.token_index (token_index),
		.column      (column),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data        (data),
		.position    (position),
		.last        (last),
		.error       (error)
	);

	// an error beat is always a single zero beat at position zero
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error) |-> (last && data == 32'd0 && position == 6'd0))
		else $error("error beat with wrong fields");

	// while a lookup row is still streaming, no new item is taken
	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> in_stall)
		else $error("item taken in the middle of a lookup row");

	// a clear beat starts the sweep at once
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action == ACT_CLEAR) |=> in_stall)
		else $error("clear did not start the sweep");

endmodule
